/* rtl/tswp_pkg.sv */
// tswp_pkg: shared types, codes and sizes for the skin weight packer
`default_nettype none

package tswp_pkg;

    localparam int unsigned VERTEX_COUNT_DEF = 4096;

    localparam int unsigned VERTEX_W   = 12;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SLOTS      = 4;
    localparam int unsigned SLOT_IDX_W = $clog2(SLOTS);
    localparam int unsigned ENTRY_W    = SLOTS * BYTE_W;
    localparam int unsigned RANK_W     = 3;

    localparam logic CMD_INSERT = 1'b0;

    localparam logic [RANK_W-1:0] RANK_NONE = 3'd0;
    localparam logic [RANK_W-1:0] RANK_FULL = 3'd5;

    // one vertex entry, slot k in bits 8k+7..8k of each word
    typedef struct packed {
        logic [ENTRY_W-1:0] weights;
        logic [ENTRY_W-1:0] matrices;
    } entry_t;

    // outcome of one request on one entry
    typedef struct packed {
        entry_t            entry;
        logic [RANK_W-1:0] rank;
        logic              wr_en;
    } upd_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

endpackage

`default_nettype wire

/* rtl/tswp_ram.sv */
// tswp_ram: generic single write port, single read port ram with registered read
`default_nettype none

module tswp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tswp_slot_update.sv */
// tswp_slot_update: slot choice and entry update for one insert or read request
`default_nettype none

module tswp_slot_update
    import tswp_pkg::*;
(
    input  wire logic              cmd,
    input  wire logic              in_range,
    input  wire logic [BYTE_W-1:0] matrix_index,
    input  wire logic [BYTE_W-1:0] weight,
    input  wire entry_t            cur,
    output upd_t                   upd
);

    logic                  found;
    logic [SLOT_IDX_W-1:0] free_pos;
    logic [SLOT_IDX_W-1:0] min_pos;
    logic [SLOT_IDX_W-1:0] tgt;
    logic                  do_put;

    // lowest free slot, and lowest slot holding the smallest weight
    always_comb
    begin
        found    = 1'b0;
        free_pos = '0;
        min_pos  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && (cur.weights[i*BYTE_W +: BYTE_W] == '0))
            begin
                found    = 1'b1;
                free_pos = SLOT_IDX_W'(i);
            end
        end
        for (int i = 1; i < SLOTS; i++)
        begin
            if (cur.weights[i*BYTE_W +: BYTE_W] < cur.weights[min_pos*BYTE_W +: BYTE_W])
            begin
                min_pos = SLOT_IDX_W'(i);
            end
        end
    end

    assign tgt    = found ? free_pos : min_pos;
    assign do_put = found || (cur.weights[min_pos*BYTE_W +: BYTE_W] < weight);

    always_comb
    begin
        upd = '0;
        if (in_range)
        begin
            upd.entry = cur;
            if (cmd == CMD_INSERT)
            begin
                upd.wr_en = 1'b1;
                upd.rank  = found ? (RANK_W'(free_pos) + RANK_W'(1)) : RANK_FULL;
                if (do_put)
                begin
                    upd.entry.weights[tgt*BYTE_W +: BYTE_W]  = weight;
                    upd.entry.matrices[tgt*BYTE_W +: BYTE_W] = matrix_index;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/top4_skin_weight_packer.sv */
// top4_skin_weight_packer: per-vertex four-slot bone weight store with insert and read
//
//  channel | signals                               | direction | request
//  --------+---------------------------------------+-----------+---------------------------
//  in      | in_valid, in_stall, cmd, vertex,      | to block  | insert or read of a vertex
//          | matrix_index, weight                  |           |
//  out     | out_valid, out_stall, weight_0..3,    | from block| slots after the request,
//          | matrix_0..3, slot_rank, max_slot_rank |           | rank and running maximum
//
// one request per cycle while results drain: the vertex entry is read from the slot
// rams at accept, updated in the update stage and written back as it advances, when the
// result is also registered; a write-back that meets a read of the same vertex is forwarded
// after reset a clearing pass zeroes the slot rams, one vertex per cycle, and in_stall
// is held high for all of it
// a stalled result holds the update stage, and in_stall then rises in the same cycle
// vertices at or above VERTEX_COUNT store nothing and return zero slots, rank 0
`default_nettype none

module top4_skin_weight_packer
    import tswp_pkg::*;
#(
    parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                cmd,
    input  wire logic [VERTEX_W-1:0] vertex,
    input  wire logic [BYTE_W-1:0]   matrix_index,
    input  wire logic [BYTE_W-1:0]   weight,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [BYTE_W-1:0]        weight_0,
    output logic [BYTE_W-1:0]        weight_1,
    output logic [BYTE_W-1:0]        weight_2,
    output logic [BYTE_W-1:0]        weight_3,
    output logic [BYTE_W-1:0]        matrix_0,
    output logic [BYTE_W-1:0]        matrix_1,
    output logic [BYTE_W-1:0]        matrix_2,
    output logic [BYTE_W-1:0]        matrix_3,
    output logic [RANK_W-1:0]        slot_rank,
    output logic [RANK_W-1:0]        max_slot_rank
);

    localparam int unsigned ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTEX_COUNT - 1);

    // clearing pass control
    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clearing;

    // handshake terms
    logic              in_accept;
    logic              s1_adv;
    logic              in_range;
    logic [ADDR_W-1:0] in_addr;

    // update stage, holds the request whose entry the rams return
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_cmd_reg;
    logic              s1_in_range_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [BYTE_W-1:0] s1_mat_reg;
    logic [BYTE_W-1:0] s1_wgt_reg;

    // write-back forwarding for a read that collided with the write of the same vertex
    logic              fwd_hit_reg;
    logic              fwd_hit_next;
    entry_t            fwd_entry_reg;

    entry_t            ram_rd;
    entry_t            cur_entry;
    upd_t              upd;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    entry_t            ram_wr_data;

    // running maximum and result register
    logic [RANK_W-1:0] max_rank_reg;
    logic [RANK_W-1:0] max_rank_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    entry_t            out_entry_reg;
    logic [RANK_W-1:0] out_rank_reg;

    // ---------------- clearing pass ----------------

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                clr_addr_next = clr_addr_reg;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // ---------------- handshake ----------------

    // update stage moves on when the result register is empty or being taken
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clearing || (s1_valid_reg && !s1_adv);
    assign in_accept = in_valid && !in_stall;

    assign in_range = 32'(vertex) < 32'(VERTEX_COUNT);
    assign in_addr  = ADDR_W'(32'(vertex));

    // ---------------- slot rams ----------------

    assign ram_wr_en   = clearing || (s1_adv && upd.wr_en);
    assign ram_wr_addr = clearing ? clr_addr_reg : s1_addr_reg;
    assign ram_wr_data = clearing ? entry_t'('0) : upd.entry;

    tswp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (VERTEX_COUNT)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data.weights),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (ram_rd.weights)
    );

    tswp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (VERTEX_COUNT)
    ) u_matrix_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data.matrices),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (ram_rd.matrices)
    );

    // ---------------- update stage ----------------

    assign s1_valid_next = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    // the ram returns the old entry when the previous request writes the same vertex
    assign fwd_hit_next = in_accept && s1_adv && upd.wr_en && (s1_addr_reg == in_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_accept || s1_adv)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg      <= cmd;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= in_addr;
            s1_mat_reg      <= matrix_index;
            s1_wgt_reg      <= weight;
            fwd_entry_reg   <= upd.entry;
        end
    end

    assign cur_entry = fwd_hit_reg ? fwd_entry_reg : ram_rd;

    tswp_slot_update u_slot_update (
        .cmd          (s1_cmd_reg),
        .in_range     (s1_in_range_reg),
        .matrix_index (s1_mat_reg),
        .weight       (s1_wgt_reg),
        .cur          (cur_entry),
        .upd          (upd)
    );

    // ---------------- result register ----------------

    assign max_rank_next = (s1_adv && upd.wr_en && (upd.rank > max_rank_reg))
                           ? upd.rank : max_rank_reg;

    assign out_valid_next = s1_adv ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rank_reg  <= RANK_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_rank_reg  <= max_rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_entry_reg <= upd.entry;
            out_rank_reg  <= upd.rank;
        end
    end

    assign out_valid     = out_valid_reg;
    assign weight_0      = out_entry_reg.weights[0*BYTE_W +: BYTE_W];
    assign weight_1      = out_entry_reg.weights[1*BYTE_W +: BYTE_W];
    assign weight_2      = out_entry_reg.weights[2*BYTE_W +: BYTE_W];
    assign weight_3      = out_entry_reg.weights[3*BYTE_W +: BYTE_W];
    assign matrix_0      = out_entry_reg.matrices[0*BYTE_W +: BYTE_W];
    assign matrix_1      = out_entry_reg.matrices[1*BYTE_W +: BYTE_W];
    assign matrix_2      = out_entry_reg.matrices[2*BYTE_W +: BYTE_W];
    assign matrix_3      = out_entry_reg.matrices[3*BYTE_W +: BYTE_W];
    assign slot_rank     = out_rank_reg;
    assign max_slot_rank = max_rank_reg;

    // ---------------- assertions ----------------

    // no request is taken while the clearing pass owns the ram write port
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_accept)
        else $error("request accepted during clearing pass");

    // forwarding only ever applies to a live request in the update stage
    a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("stale forward hit");

    // the running maximum never falls
    a_max_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (max_rank_reg >= $past(max_rank_reg)))
        else $error("running maximum decreased");

    // a delivered rank is within range and never above the running maximum
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_rank_reg <= RANK_FULL) && (out_rank_reg <= max_rank_reg)))
        else $error("slot rank out of range");

endmodule

`default_nettype wire
